>>> hw/rtl/e2q_pkg.sv
package e2q_pkg;

   // Field widths and fixed-point formats
   localparam int ANGLE_W         = 16;
   localparam int ANGLE_FRAC_BITS = 6;
   localparam int OUT_WIDTH       = 16;
   localparam int Q_FRAC          = 30;

   // CORDIC sizing
   localparam int CORDIC_STAGES_DEF = 16;
   localparam int ATAN_LEN          = 24;
   localparam int CX_W              = 33;
   localparam int TRIG_W            = 32;

   // Angle lanes
   localparam int LANES      = 3;
   localparam int LANE_YAW   = 0;
   localparam int LANE_PITCH = 1;
   localparam int LANE_ROLL  = 2;

   // Degree to binary-angle conversion: 2^(31-frac) split as quotient and remainder of 360
   localparam int DEG_PER_TURN = 360;
   localparam int MAG_W        = ANGLE_W + 1;
   localparam int QUOT_W       = 24;
   localparam int REM_W        = 9;
   localparam int PART_W       = 24;
   localparam int RECIP_W      = 24;
   localparam int RECIP_SHIFT  = 32;
   localparam int E_W          = 16;
   localparam int PHASE_W      = 32;

   localparam longint unsigned PhaseScale = 64'd1 << (31 - ANGLE_FRAC_BITS);
   localparam logic [QUOT_W-1:0]  PHASE_QUOT = QUOT_W'(PhaseScale / DEG_PER_TURN);
   localparam logic [REM_W-1:0]   PHASE_REM  = REM_W'(PhaseScale % DEG_PER_TURN);
   localparam logic [PART_W-1:0]  PHASE_HALF = PART_W'(DEG_PER_TURN / 2);
   localparam logic [RECIP_W-1:0] RECIP_TURN =
      RECIP_W'(((64'd1 << RECIP_SHIFT) + DEG_PER_TURN - 1) / DEG_PER_TURN);

   // Rotation constants, Q30 and binary angle (2^32 per turn)
   localparam logic signed [CX_W-1:0] CORDIC_GAIN = 33'sd652032874;
   localparam logic signed [CX_W-1:0] QUARTER_TURN = 33'sd1073741824;
   localparam logic signed [CX_W-1:0] HALF_TURN    = 33'sd2147483648;

   localparam logic [PHASE_W-1:0] ATAN_PHASE [ATAN_LEN] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
      32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
      32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
      32'd166886,    32'd83443,     32'd41722,     32'd20861,
      32'd10430,     32'd5215,      32'd2608,      32'd1304,
      32'd652,       32'd326,       32'd163,       32'd81
   };

   // Transaction payloads
   typedef struct packed {
      logic signed [ANGLE_W-1:0] yaw_angle;
      logic signed [ANGLE_W-1:0] pitch_angle;
      logic signed [ANGLE_W-1:0] roll_angle;
   } req_type;

   typedef struct packed {
      logic signed [OUT_WIDTH-1:0] quat_w;
      logic signed [OUT_WIDTH-1:0] quat_x;
      logic signed [OUT_WIDTH-1:0] quat_y;
      logic signed [OUT_WIDTH-1:0] quat_z;
   } rsp_type;

endpackage

>>> hw/rtl/euler_to_quaternion_top.sv
// Euler Z-Y-X angles to unit quaternion converter.
// Input channel req_*: one transaction carries yaw, pitch and roll as signed
// angles in 1/64 degree. Every 16-bit pattern is legal; angles wrap cleanly.
// Result channel rsp_*: one transaction per input, quat_w/x/y/z in Q1.15,
// with +1.0 saturated to 32767.
// Throughput: one transaction per clock while req_stall is low. From input
// acceptance to rsp_valid the data passes degree-to-phase conversion and
// folding, the CORDIC micro-rotations, the sign fix, the product tree and
// one output register.
// The three angles run in parallel CORDIC lanes, so the rate is one item
// per clock in every stage while the pipeline is not frozen.
// Reset (synchronous, active high) empties the pipeline and both output
// slots; no result is pending afterwards. No configuration is needed.
// When the receiver stalls, the held result stays in the output register
// and one more result is caught in a skid register; only then does req_stall
// rise and the whole pipeline freeze until the receiver takes a result.
module euler_to_quaternion_top
   import e2q_pkg::*;
#(
   parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int PR_W   = 2 * TRIG_W;
   localparam int PQ_W   = 33;
   localparam int TR_W   = PQ_W + TRIG_W;
   localparam int SUM_W  = PQ_W + 1;
   localparam int R_W    = SUM_W + 1;
   localparam int NPAIR  = 4;
   localparam int NTRI   = 8;
   localparam int NQUAT  = 4;
   localparam int PSTG   = 5;
   localparam int OUT_SHIFT = Q_FRAC + 1 - OUT_WIDTH;

   // Pair product slots
   localparam int PR_CC = 0;
   localparam int PR_SS = 1;
   localparam int PR_SC = 2;
   localparam int PR_CS = 3;

   localparam logic signed [PR_W-1:0] PR_HALF = PR_W'(1) << (Q_FRAC - 1);
   localparam logic signed [TR_W-1:0] TR_HALF = TR_W'(1) << (Q_FRAC - 1);
   localparam logic signed [R_W-1:0]  OUT_MAX = R_W'((64'sd1 <<< (OUT_WIDTH - 1)) - 64'sd1);
   localparam logic signed [R_W-1:0]  OUT_MIN = -OUT_MAX - R_W'(1);

   logic                     advance;
   logic                     cor_vld;
   logic signed [ANGLE_W-1:0] angle [LANES];
   logic signed [TRIG_W-1:0] cs [LANES];
   logic signed [TRIG_W-1:0] sn [LANES];

   logic [PSTG-1:0]          pv_ff;
   logic signed [PR_W-1:0]   pr_ff  [NPAIR];
   logic signed [PQ_W-1:0]   pq_ff  [NPAIR];
   logic signed [TR_W-1:0]   tr_ff  [NTRI];
   logic signed [PQ_W-1:0]   tq_ff  [NTRI];
   logic signed [SUM_W-1:0]  sum_ff [NQUAT];
   logic signed [TRIG_W-1:0] cy1_ff, sy1_ff, cy2_ff, sy2_ff;

   logic signed [PR_W-1:0]   pr_in  [NPAIR];
   logic signed [TR_W-1:0]   tr_in  [NTRI];
   logic signed [SUM_W-1:0]  sum_in [NQUAT];
   logic signed [OUT_WIDTH-1:0] quat [NQUAT];

   rsp_type rsp_data_ff, rsp_data_in, skid_data_ff, skid_data_in, result;
   logic    rsp_valid_ff, rsp_valid_in, skid_vld_ff, skid_vld_in;
   logic    take, incoming;

   // Freeze the pipeline only while the skid register is occupied
   assign advance   = !skid_vld_ff;
   assign req_stall = skid_vld_ff;

   assign angle[LANE_YAW]   = req_data.yaw_angle;
   assign angle[LANE_PITCH] = req_data.pitch_angle;
   assign angle[LANE_ROLL]  = req_data.roll_angle;

   e2q_cordic #(
      .CORDIC_STAGES(CORDIC_STAGES)
   ) u_cordic (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .in_vld  (req_valid && advance),
      .in_angle(angle),
      .out_vld (cor_vld),
      .cos_out (cs),
      .sin_out (sn)
   );

   // Valid bits of the product tree
   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff <= '0;
      end else if (advance) begin
         pv_ff <= {pv_ff[PSTG-2:0], cor_vld};
      end
   end

   // Roll-pitch pair products
   assign pr_in[PR_CC] = PR_W'(cs[LANE_ROLL]) * PR_W'(cs[LANE_PITCH]);
   assign pr_in[PR_SS] = PR_W'(sn[LANE_ROLL]) * PR_W'(sn[LANE_PITCH]);
   assign pr_in[PR_SC] = PR_W'(sn[LANE_ROLL]) * PR_W'(cs[LANE_PITCH]);
   assign pr_in[PR_CS] = PR_W'(cs[LANE_ROLL]) * PR_W'(sn[LANE_PITCH]);

   // Triple products with the yaw terms
   assign tr_in[0] = TR_W'(pq_ff[PR_CC]) * TR_W'(cy2_ff);
   assign tr_in[1] = TR_W'(pq_ff[PR_SS]) * TR_W'(sy2_ff);
   assign tr_in[2] = TR_W'(pq_ff[PR_SC]) * TR_W'(cy2_ff);
   assign tr_in[3] = TR_W'(pq_ff[PR_CS]) * TR_W'(sy2_ff);
   assign tr_in[4] = TR_W'(pq_ff[PR_CS]) * TR_W'(cy2_ff);
   assign tr_in[5] = TR_W'(pq_ff[PR_SC]) * TR_W'(sy2_ff);
   assign tr_in[6] = TR_W'(pq_ff[PR_CC]) * TR_W'(sy2_ff);
   assign tr_in[7] = TR_W'(pq_ff[PR_SS]) * TR_W'(cy2_ff);

   // Combine into w, x, y, z
   assign sum_in[0] = SUM_W'(tq_ff[0]) + SUM_W'(tq_ff[1]);
   assign sum_in[1] = SUM_W'(tq_ff[2]) - SUM_W'(tq_ff[3]);
   assign sum_in[2] = SUM_W'(tq_ff[4]) + SUM_W'(tq_ff[5]);
   assign sum_in[3] = SUM_W'(tq_ff[6]) - SUM_W'(tq_ff[7]);

   genvar gk;
   for (gk = 0; gk < NPAIR; gk++) begin : g_pair
      logic signed [PR_W-1:0] rnd;
      assign rnd = pr_ff[gk] + PR_HALF;
      always_ff @(posedge clock) begin
         if (advance) begin
            pr_ff[gk] <= pr_in[gk];
            pq_ff[gk] <= rnd[Q_FRAC +: PQ_W];
         end
      end
   end

   for (gk = 0; gk < NTRI; gk++) begin : g_tri
      logic signed [TR_W-1:0] rnd;
      assign rnd = tr_ff[gk] + TR_HALF;
      always_ff @(posedge clock) begin
         if (advance) begin
            tr_ff[gk] <= tr_in[gk];
            tq_ff[gk] <= rnd[Q_FRAC +: PQ_W];
         end
      end
   end

   // Carry the yaw cosine and sine alongside the pair products
   always_ff @(posedge clock) begin
      if (advance) begin
         cy1_ff <= cs[LANE_YAW];
         sy1_ff <= sn[LANE_YAW];
         cy2_ff <= cy1_ff;
         sy2_ff <= sy1_ff;
      end
   end

   // Round to the output format and saturate
   for (gk = 0; gk < NQUAT; gk++) begin : g_quat
      logic signed [R_W-1:0] vx;
      logic signed [R_W-1:0] rr;

      always_ff @(posedge clock) begin
         if (advance) begin
            sum_ff[gk] <= sum_in[gk];
         end
      end

      assign vx = R_W'(sum_ff[gk]);

      if (OUT_SHIFT > 0) begin : g_down
         localparam logic signed [R_W-1:0] OUT_HALF = R_W'(1) << (OUT_SHIFT - 1);
         assign rr = (vx + OUT_HALF) >>> OUT_SHIFT;
      end else if (OUT_SHIFT == 0) begin : g_same
         assign rr = vx;
      end else begin : g_up
         assign rr = vx <<< (-OUT_SHIFT);
      end

      always_comb begin
         if (rr > OUT_MAX) begin
            quat[gk] = OUT_MAX[OUT_WIDTH-1:0];
         end else if (rr < OUT_MIN) begin
            quat[gk] = OUT_MIN[OUT_WIDTH-1:0];
         end else begin
            quat[gk] = rr[OUT_WIDTH-1:0];
         end
      end
   end

   assign result.quat_w = quat[0];
   assign result.quat_x = quat[1];
   assign result.quat_y = quat[2];
   assign result.quat_z = quat[3];

   // Output register with one skid slot
   assign take     = rsp_valid_ff && !rsp_stall;
   assign incoming = pv_ff[PSTG-1] && advance;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      skid_vld_in  = skid_vld_ff;
      skid_data_in = skid_data_ff;
      if (skid_vld_ff) begin
         if (take) begin
            rsp_data_in = skid_data_ff;
            skid_vld_in = 1'b0;
         end
      end else if (incoming) begin
         if (!rsp_valid_ff || take) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = result;
         end else begin
            skid_vld_in  = 1'b1;
            skid_data_in = result;
         end
      end else if (take) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         skid_vld_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         skid_vld_ff  <= skid_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // The skid slot only holds a result behind a pending one
   a_skid_behind: assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff |-> rsp_valid_ff)
      else $error("skid holds a result with the output register empty");

   // The skid slot fills only behind a stalled result
   a_skid_fill: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_vld_ff) |-> $past(rsp_valid_ff && rsp_stall))
      else $error("skid filled without a stalled output");

   // A result arriving behind a stalled one is caught, not dropped
   a_skid_catch: assert property (@(posedge clock) disable iff (reset)
      (incoming && rsp_valid_ff && rsp_stall) |=> skid_vld_ff)
      else $error("result dropped under stall");

endmodule

>>> hw/rtl/e2q_cordic.sv
module e2q_cordic
   import e2q_pkg::*;
#(
   parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  logic                     in_vld,
   input  logic signed [ANGLE_W-1:0] in_angle [LANES],
   output logic                     out_vld,
   output logic signed [TRIG_W-1:0] cos_out [LANES],
   output logic signed [TRIG_W-1:0] sin_out [LANES]
);

   localparam int NR    = (CORDIC_STAGES < ATAN_LEN) ? CORDIC_STAGES : ATAN_LEN;
   localparam int PRE   = 5;
   localparam int DEPTH = PRE + NR + 1;
   localparam int FOLD  = PRE - 1;

   logic [DEPTH-1:0] vld_ff;

   logic [MAG_W-1:0]    mag_ff   [LANES];
   logic                neg_ff   [LANES];
   logic [PHASE_W-1:0]  hi_ff    [LANES];
   logic [PART_W-1:0]   part_ff  [LANES];
   logic                neg2_ff  [LANES];
   logic [PHASE_W-1:0]  hi2_ff   [LANES];
   logic [E_W-1:0]      quo_ff   [LANES];
   logic                neg3_ff  [LANES];
   logic [PHASE_W-1:0]  phase_ff [LANES];
   logic signed [CX_W-1:0] fz_ff [LANES];
   logic                fflip_ff [LANES];

   logic signed [CX_W-1:0] cx_ff [NR][LANES];
   logic signed [CX_W-1:0] cy_ff [NR][LANES];
   logic signed [CX_W-1:0] cz_ff [NR][LANES];
   logic                   cf_ff [NR][LANES];

   logic signed [TRIG_W-1:0] cos_ff [LANES];
   logic signed [TRIG_W-1:0] sin_ff [LANES];

   // Advance valid bits with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[DEPTH-2:0], in_vld};
      end
   end

   assign out_vld = vld_ff[DEPTH-1];

   genvar gl, gi;
   for (gl = 0; gl < LANES; gl++) begin : g_pre
      logic [MAG_W-1:0]          mag_in;
      logic [MAG_W+QUOT_W-1:0]   hi_wide;
      logic [MAG_W+REM_W-1:0]    part_wide;
      logic [PART_W+RECIP_W-1:0] quo_wide;
      logic [PHASE_W-1:0]        sum32;
      logic [PHASE_W-1:0]        phase_in;
      logic signed [CX_W-1:0]    zs;
      logic signed [CX_W-1:0]    fz_in;
      logic                      fflip_in;

      // Magnitude and sign of the angle
      always_comb begin
         if (in_angle[gl] < 0) begin
            mag_in = MAG_W'(-(MAG_W'(in_angle[gl])));
         end else begin
            mag_in = MAG_W'(in_angle[gl]);
         end
      end

      // Split the scaled magnitude into whole turns of 360 and a remainder part
      assign hi_wide   = (MAG_W+QUOT_W)'(mag_ff[gl]) * (MAG_W+QUOT_W)'(PHASE_QUOT);
      assign part_wide = (MAG_W+REM_W)'(mag_ff[gl]) * (MAG_W+REM_W)'(PHASE_REM)
                       + (MAG_W+REM_W)'(PHASE_HALF);

      // Divide the remainder part by 360 through the reciprocal
      assign quo_wide = (PART_W+RECIP_W)'(part_ff[gl]) * (PART_W+RECIP_W)'(RECIP_TURN);

      // Merge and apply sign, modulo one turn
      assign sum32    = hi2_ff[gl] + PHASE_W'(quo_ff[gl]);
      assign phase_in = neg3_ff[gl] ? (~sum32 + PHASE_W'(1)) : sum32;

      // Fold the half angle into +-90 degrees
      assign zs = CX_W'($signed(phase_ff[gl]));
      always_comb begin
         fz_in    = zs;
         fflip_in = 1'b0;
         if (zs > QUARTER_TURN) begin
            fz_in    = zs - HALF_TURN;
            fflip_in = 1'b1;
         end else if (zs < -QUARTER_TURN) begin
            fz_in    = zs + HALF_TURN;
            fflip_in = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            mag_ff[gl]   <= mag_in;
            neg_ff[gl]   <= in_angle[gl][ANGLE_W-1];
            hi_ff[gl]    <= hi_wide[PHASE_W-1:0];
            part_ff[gl]  <= part_wide[PART_W-1:0];
            neg2_ff[gl]  <= neg_ff[gl];
            hi2_ff[gl]   <= hi_ff[gl];
            quo_ff[gl]   <= quo_wide[RECIP_SHIFT +: E_W];
            neg3_ff[gl]  <= neg2_ff[gl];
            phase_ff[gl] <= phase_in;
            fz_ff[gl]    <= fz_in;
            fflip_ff[gl] <= fflip_in;
         end
      end
   end

   // One micro-rotation per stage
   for (gi = 0; gi < NR; gi++) begin : g_stage
      for (gl = 0; gl < LANES; gl++) begin : g_lane
         logic signed [CX_W-1:0] xa;
         logic signed [CX_W-1:0] ya;
         logic signed [CX_W-1:0] za;
         logic                   fa;
         logic signed [CX_W-1:0] dx;
         logic signed [CX_W-1:0] dy;
         logic signed [CX_W-1:0] at;
         logic signed [CX_W-1:0] cx_in;
         logic signed [CX_W-1:0] cy_in;
         logic signed [CX_W-1:0] cz_in;

         if (gi == 0) begin : g_first
            assign xa = CORDIC_GAIN;
            assign ya = '0;
            assign za = fz_ff[gl];
            assign fa = fflip_ff[gl];
         end else begin : g_next
            assign xa = cx_ff[gi-1][gl];
            assign ya = cy_ff[gi-1][gl];
            assign za = cz_ff[gi-1][gl];
            assign fa = cf_ff[gi-1][gl];
         end

         assign dx = ya >>> gi;
         assign dy = xa >>> gi;
         assign at = $signed({1'b0, ATAN_PHASE[gi]});

         always_comb begin
            if (za >= 0) begin
               cx_in = xa - dx;
               cy_in = ya + dy;
               cz_in = za - at;
            end else begin
               cx_in = xa + dx;
               cy_in = ya - dy;
               cz_in = za + at;
            end
         end

         always_ff @(posedge clock) begin
            if (advance) begin
               cx_ff[gi][gl] <= cx_in;
               cy_ff[gi][gl] <= cy_in;
               cz_ff[gi][gl] <= cz_in;
               cf_ff[gi][gl] <= fa;
            end
         end
      end
   end

   // Undo the fold: negate cosine and sine
   for (gl = 0; gl < LANES; gl++) begin : g_out
      logic signed [CX_W-1:0] xl;
      logic signed [CX_W-1:0] yl;
      logic signed [CX_W-1:0] cos_in;
      logic signed [CX_W-1:0] sin_in;

      assign xl     = cx_ff[NR-1][gl];
      assign yl     = cy_ff[NR-1][gl];
      assign cos_in = cf_ff[NR-1][gl] ? -xl : xl;
      assign sin_in = cf_ff[NR-1][gl] ? -yl : yl;

      always_ff @(posedge clock) begin
         if (advance) begin
            cos_ff[gl] <= cos_in[TRIG_W-1:0];
            sin_ff[gl] <= sin_in[TRIG_W-1:0];
         end
      end

      assign cos_out[gl] = cos_ff[gl];
      assign sin_out[gl] = sin_ff[gl];
   end

   // Folded phase stays within one quarter turn of zero
   a_fold_range: assert property (@(posedge clock) disable iff (reset)
      vld_ff[FOLD] |->
         (fz_ff[LANE_YAW]   <= QUARTER_TURN) && (fz_ff[LANE_YAW]   >= -QUARTER_TURN) &&
         (fz_ff[LANE_PITCH] <= QUARTER_TURN) && (fz_ff[LANE_PITCH] >= -QUARTER_TURN) &&
         (fz_ff[LANE_ROLL]  <= QUARTER_TURN) && (fz_ff[LANE_ROLL]  >= -QUARTER_TURN))
      else $error("folded phase out of range");

   // A negative yaw angle never has zero magnitude
   a_neg_mag: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[0] && neg_ff[LANE_YAW]) |-> (mag_ff[LANE_YAW] != '0))
      else $error("negative angle with zero magnitude");

   // Hold every valid bit while the pipeline is frozen
   a_frozen: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(vld_ff))
      else $error("valid chain moved while frozen");

endmodule
